/* rtl/spt_pkg.sv */
// Shared types and constants for the stereo frame timestamp pairer.
// Holds payload structs, command and state enums and register codes.
// No dependencies; every other file but spt_stream_if imports this package.
package spt_pkg;

  localparam int StampW = 32;
  localparam int TagW   = 8;
  localparam int DiffW  = 20;
  localparam int LimitW = 4;
  localparam int ModeW  = 2;
  localparam int CfgIdxW = 1;

  localparam logic [DiffW-1:0]  MaxDiffReset   = 20'd50000;
  localparam logic [LimitW-1:0] FifoLimitReset = 4'd3;

  // Input event codes; the fourth code is unused and ignored.
  typedef enum logic [ModeW-1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_DIFF   = 1'b0,
    REG_FIFO_LIMIT = 1'b1
  } reg_idx_e;

  // Per-cell data source select.
  typedef enum logic [1:0] {
    CS_HOLD = 2'd0,
    CS_NEXT = 2'd1,
    CS_HEAD = 2'd2,
    CS_NEW  = 2'd3
  } cell_sel_e;

  // Operations on one side's cell chain.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_DROP   = 2'd3
  } chain_cmd_e;

  // Top-level controller states.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [TagW-1:0]   frame_tag;
    logic [StampW-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [TagW-1:0]   left_tag;
    logic [TagW-1:0]   right_tag;
    logic [StampW-1:0] pair_stamp;
  } out_item_t;

  // One stored frame.
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] stamp;
  } entry_t;

endpackage

/* rtl/spt_stream_if.sv */
// Valid/ready stream interface used for the input and result channels.
// The payload type is a parameter; the pairer uses structs from spt_pkg.
interface spt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/spt_cell.sv */
// One storage cell of a frame chain: holds a tag and a stamp.
// Loads from its neighbor, from the chain head or from a new frame; uses spt_pkg.
module spt_cell (
  input  logic               clk_i,
  input  spt_pkg::cell_sel_e sel_i,
  input  spt_pkg::entry_t    next_i,
  input  spt_pkg::entry_t    head_i,
  input  spt_pkg::entry_t    new_i,
  output spt_pkg::entry_t    data_o
);
  import spt_pkg::*;

  entry_t data_q, data_d;

  // Pick the source for this cycle.
  always_comb begin
    case (sel_i)
      CS_NEXT: data_d = next_i;
      CS_HEAD: data_d = head_i;
      CS_NEW:  data_d = new_i;
      default: data_d = data_q;
    endcase
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/spt_chain.sv */
// One side's frame queue: a row of spt_cell cells, oldest at cell 0, plus the fill count.
// Supports push with oldest-drop, circular rotation and drop-through-index; uses spt_pkg.
module spt_chain #(
  parameter int MAX_DEPTH = 8,
  localparam int CW = $clog2(MAX_DEPTH + 1),
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spt_pkg::chain_cmd_e        cmd_i,
  input  logic [IW-1:0]              idx_i,
  input  spt_pkg::entry_t            new_i,
  input  logic [spt_pkg::LimitW-1:0] fifo_limit_i,
  output spt_pkg::entry_t            head_o,
  output logic [CW-1:0]              count_o
);
  import spt_pkg::*;

  localparam int LW = (CW > LimitW) ? CW : LimitW;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_m1;
  logic [LW-1:0] lim_raw, lim;
  logic          full;
  entry_t        cell_data [MAX_DEPTH];
  cell_sel_e     cell_sel  [MAX_DEPTH];

  // Effective limit: zero acts as one, large values saturate to the depth.
  always_comb begin
    lim_raw = (fifo_limit_i == '0) ? LW'(1) : LW'(fifo_limit_i);
    lim     = (lim_raw > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : lim_raw;
    full    = (LW'(count_q) >= lim) || (count_q >= CW'(MAX_DEPTH));
  end

  assign count_m1 = count_q - CW'(1);

  // Cells and their per-position select.
  for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_cell
    localparam logic [CW-1:0] KPos = CW'(k);
    entry_t next_data;

    if (k == MAX_DEPTH - 1) begin : g_last
      assign next_data = cell_data[0];
    end else begin : g_mid
      assign next_data = cell_data[k+1];
    end

    always_comb begin
      cell_sel[k] = CS_HOLD;
      case (cmd_i)
        CMD_PUSH: begin
          if (full) begin
            if (KPos < count_m1) begin
              cell_sel[k] = CS_NEXT;
            end else if (KPos == count_m1) begin
              cell_sel[k] = CS_NEW;
            end
          end else if (KPos == count_q) begin
            cell_sel[k] = CS_NEW;
          end
        end
        CMD_ROTATE, CMD_DROP: begin
          if (KPos < count_m1) begin
            cell_sel[k] = CS_NEXT;
          end else if (KPos == count_m1) begin
            cell_sel[k] = CS_HEAD;
          end
        end
        default: cell_sel[k] = CS_HOLD;
      endcase
    end

    spt_cell u_cell (
      .clk_i  (clk_i),
      .sel_i  (cell_sel[k]),
      .next_i (next_data),
      .head_i (cell_data[0]),
      .new_i  (new_i),
      .data_o (cell_data[k])
    );
  end

  // Fill count update.
  always_comb begin
    case (cmd_i)
      CMD_PUSH: count_d = full ? count_q : count_q + CW'(1);
      CMD_DROP: count_d = count_m1 - CW'(idx_i);
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = cell_data[0];
  assign count_o = count_q;

endmodule

/* rtl/stereo_frame_timestamp_pairer.sv */
// A left or right frame transaction is stored as it is accepted; the input stays ready, so
// frames may follow back to back. A sync tick is accepted and, with both sides non-empty, walks
// left entries oldest first and right entries oldest first, one pair per cycle, up to L*R pairs
// (L and R are the two fill counts, at most MAX_DEPTH squared, 64 at the default depth). The
// walk is set by a single stamp comparator looking at the heads of two rotating cell chains.
// A match ends the walk at once; a match found while the previous result is still waiting on
// the output stalls the walk until that result is taken. There is no clearing pass after reset.
//
// Top level: controller, configuration registers and result register.
// Depends on spt_pkg, spt_stream_if and spt_chain.
module stereo_frame_timestamp_pairer #(
  parameter int MAX_DEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  spt_stream_if.sink                  in_i,
  spt_stream_if.source                out_o,
  input  logic                        cfg_we_i,
  input  logic [spt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [spt_pkg::DiffW-1:0]   cfg_data_i
);
  import spt_pkg::*;

  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  state_e            state_q, state_d;
  logic [IW-1:0]     i_q, i_d, j_q, j_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;
  logic [DiffW-1:0]  max_diff_q;
  logic [LimitW-1:0] fifo_limit_q;

  chain_cmd_e        left_cmd, right_cmd;
  logic [IW-1:0]     left_idx, right_idx;
  entry_t            left_head, right_head, new_entry;
  logic [CW-1:0]     left_count, right_count;
  logic [StampW-1:0] gap;
  logic              match, emit, accept, i_last, j_last;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_diff_q   <= MaxDiffReset;
      fifo_limit_q <= FifoLimitReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAX_DIFF:   max_diff_q   <= cfg_data_i;
        REG_FIFO_LIMIT: fifo_limit_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign new_entry.tag   = in_i.payload.frame_tag;
  assign new_entry.stamp = in_i.payload.stamp;

  // Stamp gap between the two chain heads.
  always_comb begin
    if (left_head.stamp >= right_head.stamp) begin
      gap = left_head.stamp - right_head.stamp;
    end else begin
      gap = right_head.stamp - left_head.stamp;
    end
    match = gap < StampW'(max_diff_q);
  end

  assign i_last = (CW'(i_q) == left_count - CW'(1));
  assign j_last = (CW'(j_q) == right_count - CW'(1));

  // Controller: next state, chain commands and result load.
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    left_cmd    = CMD_HOLD;
    right_cmd   = CMD_HOLD;
    left_idx    = i_q;
    right_idx   = j_q;
    emit        = 1'b0;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_e'(in_i.payload.mode))
            MODE_LEFT:  left_cmd  = CMD_PUSH;
            MODE_RIGHT: right_cmd = CMD_PUSH;
            MODE_TICK: begin
              if (left_count != '0 && right_count != '0) begin
                state_d = ST_SEARCH;
                i_d     = '0;
                j_d     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (match) begin
          if (!out_valid_q || out_o.ready) begin
            emit                  = 1'b1;
            out_valid_d           = 1'b1;
            out_item_d.left_tag   = left_head.tag;
            out_item_d.right_tag  = right_head.tag;
            out_item_d.pair_stamp = left_head.stamp;
            left_cmd              = CMD_DROP;
            right_cmd             = CMD_DROP;
            state_d               = ST_IDLE;
          end
        end else begin
          // Step to the next right entry; after the last one, to the next left entry.
          right_cmd = CMD_ROTATE;
          if (j_last) begin
            left_cmd = CMD_ROTATE;
            j_d      = '0;
            if (i_last) begin
              state_d = ST_IDLE;
            end else begin
              i_d = i_q + IW'(1);
            end
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  spt_chain #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_left (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (left_cmd),
    .idx_i        (left_idx),
    .new_i        (new_entry),
    .fifo_limit_i (fifo_limit_q),
    .head_o       (left_head),
    .count_o      (left_count)
  );

  spt_chain #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_right (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (right_cmd),
    .idx_i        (right_idx),
    .new_i        (new_entry),
    .fifo_limit_i (fifo_limit_q),
    .head_o       (right_head),
    .count_o      (right_count)
  );

  // A walk only runs while both sides hold entries.
  a_search_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (left_count != '0 && right_count != '0))
    else $error("walk running with an empty side");

  // Walk indexes stay inside the filled part of each chain.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (CW'(i_q) < left_count && CW'(j_q) < right_count))
    else $error("walk index beyond fill count");

  // Fill counts never exceed the chain depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_count <= CW'(MAX_DEPTH)) && (right_count <= CW'(MAX_DEPTH)))
    else $error("fill count beyond depth");

  // A result is loaded only when the output slot is free or being emptied.
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_o.ready))
    else $error("result overwrote a pending transaction");

  // Each match returns to idle and leaves the result pending.
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (state_q == ST_IDLE && out_valid_q))
    else $error("match did not finish the walk");

endmodule

/* tb/stereo_frame_timestamp_pairer_tb.sv */
// Testbench for the stereo frame timestamp pairer: directed and random frame and tick traffic.
// Predicts matched pairs in a behavioral model of both frame FIFOs and checks every result.
// Depends on spt_pkg, spt_stream_if and the stereo_frame_timestamp_pairer RTL.
`timescale 1ns / 1ps

module stereo_frame_timestamp_pairer_tb;
  import spt_pkg::*;

  localparam int MaxDepth      = 8;
  localparam int SideLeft      = 0;
  localparam int SideRight     = 1;
  localparam int WalkCycles    = MaxDepth * MaxDepth + 16;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseItems    = 305;
  localparam int NumPhases     = 6;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  logic clk_i;
  logic rst_n;
  logic cfg_we;
  reg_idx_e cfg_idx;
  logic [DiffW-1:0] cfg_data;

  spt_stream_if #(.T(in_item_t))  frame_if ();
  spt_stream_if #(.T(out_item_t)) pair_if ();

  stereo_frame_timestamp_pairer #(
    .MAX_DEPTH(MaxDepth)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_n),
    .in_i      (frame_if),
    .out_o     (pair_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Frame FIFO model and its copy of the registers.
  logic [StampW-1:0] held_stamp [2][MaxDepth];
  logic [TagW-1:0]   held_tag   [2][MaxDepth];
  int                held_count [2];
  logic [DiffW-1:0]  diff_setting;
  logic [LimitW-1:0] limit_setting;

  in_item_t  frame_queue[$];
  out_item_t expected_pairs[$];

  int mismatch_count;
  int quiet_cycles;
  int hold_requests;
  int holds_done;
  int hold_left;
  bit steady_run;

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR pair check at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Removes the n oldest entries of one side.
  function automatic void drop_oldest(input int side, input int n);
    int k;
    if (n >= held_count[side]) begin
      held_count[side] = 0;
    end else begin
      for (k = 0; k < held_count[side] - n; k++) begin
        held_stamp[side][k] = held_stamp[side][k + n];
        held_tag[side][k]   = held_tag[side][k + n];
      end
      held_count[side] -= n;
    end
  endfunction

  // Pushes one frame, dropping the oldest one first when the side is at its limit.
  function automatic void store_frame(input int side, input logic [TagW-1:0] tag,
                                      input logic [StampW-1:0] stamp);
    int lim;
    lim = int'(limit_setting);
    if (lim == 0) lim = 1;
    if (lim > MaxDepth) lim = MaxDepth;
    if (held_count[side] >= lim) drop_oldest(side, 1);
    if (held_count[side] >= MaxDepth) drop_oldest(side, 1);
    held_stamp[side][held_count[side]] = stamp;
    held_tag[side][held_count[side]]   = tag;
    held_count[side]++;
  endfunction

  // Applies one accepted transaction to the model; a matching tick yields one pair.
  function automatic void track_frame(input in_item_t item);
    int i;
    int j;
    int li;
    int rj;
    bit found;
    logic [StampW-1:0] gap;
    out_item_t pair;
    found = 1'b0;
    li = 0;
    rj = 0;
    case (item.mode)
      MODE_LEFT: begin
        store_frame(SideLeft, item.frame_tag, item.stamp);
      end
      MODE_RIGHT: begin
        store_frame(SideRight, item.frame_tag, item.stamp);
      end
      MODE_TICK: begin
        // Left-major, right-minor search for the first pair inside the window.
        for (i = 0; i < held_count[SideLeft] && !found; i++) begin
          for (j = 0; j < held_count[SideRight] && !found; j++) begin
            if (held_stamp[SideLeft][i] >= held_stamp[SideRight][j]) begin
              gap = held_stamp[SideLeft][i] - held_stamp[SideRight][j];
            end else begin
              gap = held_stamp[SideRight][j] - held_stamp[SideLeft][i];
            end
            if (gap < {{(StampW - DiffW){1'b0}}, diff_setting}) begin
              found = 1'b1;
              li = i;
              rj = j;
            end
          end
        end
        if (found) begin
          pair.left_tag   = held_tag[SideLeft][li];
          pair.right_tag  = held_tag[SideRight][rj];
          pair.pair_stamp = held_stamp[SideLeft][li];
          expected_pairs = {expected_pairs, pair};
          drop_oldest(SideLeft, li + 1);
          drop_oldest(SideRight, rj + 1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_pair(input out_item_t got);
    out_item_t want;
    if (expected_pairs.size() == 0) begin
      report_mismatch($sformatf("pair %0d/%0d stamp %0d with none expected",
                                got.left_tag, got.right_tag, got.pair_stamp));
    end else begin
      want = expected_pairs.pop_front();
      if (got.left_tag !== want.left_tag)
        report_mismatch($sformatf("left_tag got %0d want %0d", got.left_tag, want.left_tag));
      if (got.right_tag !== want.right_tag)
        report_mismatch($sformatf("right_tag got %0d want %0d", got.right_tag, want.right_tag));
      if (got.pair_stamp !== want.pair_stamp)
        report_mismatch($sformatf("pair_stamp got %0d want %0d",
                                  got.pair_stamp, want.pair_stamp));
    end
  endtask

  // Input driver: offers queued transactions and feeds accepted ones to the model.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (frame_if.valid && frame_if.ready) track_frame(frame_if.payload);
      if (!frame_if.valid || frame_if.ready) begin
        if (frame_queue.size() != 0 && (steady_run || $urandom_range(99) >= 15)) begin
          frame_if.valid   <= 1'b1;
          frame_if.payload <= frame_queue.pop_front();
        end else begin
          frame_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        pair_if.ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HoldCycles;
        pair_if.ready <= 1'b0;
      end else begin
        pair_if.ready <= steady_run || $urandom_range(99) >= 15;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_n && pair_if.valid && pair_if.ready) check_pair(pair_if.payload);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((frame_if.valid && frame_if.ready) || (pair_if.valid && pair_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic queue_frame(input logic [ModeW-1:0] mode, input logic [TagW-1:0] tag,
                             input logic [StampW-1:0] stamp);
    in_item_t item;
    item.mode      = mode;
    item.frame_tag = tag;
    item.stamp     = stamp;
    frame_queue = {frame_queue, item};
  endtask

  // Waits until all transactions are taken and all pairs have arrived, then lets a
  // full tick walk pass so the block is idle.
  task automatic drain();
    do @(negedge clk_i);
    while (frame_queue.size() != 0 || frame_if.valid || expected_pairs.size() != 0);
    repeat (WalkCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(input reg_idx_e idx, input logic [DiffW-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_DIFF) begin
      diff_setting = value;
    end else begin
      limit_setting = value[LimitW-1:0];
    end
  endtask

  // Mostly bursts of left and right frames around a common time followed by a tick,
  // with single random transactions and stray ticks mixed in.
  task automatic queue_random(input int n);
    int queued;
    int roll;
    int nl;
    int nr;
    int spread;
    logic [StampW-1:0] base;
    queued = 0;
    base = $urandom();
    while (queued < n) begin
      roll = $urandom_range(99);
      spread = (diff_setting == 0) ? 64 : 2 * int'(diff_setting);
      if ($urandom_range(19) == 0) begin
        base = $urandom();
      end else begin
        base = base + $urandom_range(40000, 20000);
      end
      if (roll < 80) begin
        nl = $urandom_range(3, 1);
        nr = $urandom_range(3, 1);
        while (nl + nr > 0) begin
          if (nr == 0 || (nl != 0 && $urandom_range(1) == 0)) begin
            queue_frame(MODE_LEFT, TagW'($urandom_range(255)),
                        base + $urandom_range(spread));
            nl--;
          end else begin
            queue_frame(MODE_RIGHT, TagW'($urandom_range(255)),
                        base + $urandom_range(spread));
            nr--;
          end
          queued++;
        end
        queue_frame(MODE_TICK, TagW'($urandom_range(255)), $urandom());
        queued++;
      end else if (roll < 95) begin
        queue_frame(ModeW'($urandom_range(3)), TagW'($urandom_range(255)), $urandom());
        queued++;
      end else begin
        queue_frame(MODE_TICK, TagW'($urandom_range(255)), $urandom());
        queue_frame(MODE_TICK, TagW'($urandom_range(255)), $urandom());
        queued += 2;
      end
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin
    logic [DiffW-1:0]  phase_diff  [NumPhases];
    logic [LimitW-1:0] phase_limit [NumPhases];
    int p;
    phase_diff  = '{20'd50000, 20'd1000000, 20'd1, 20'd20000, 20'hFFFFF, 20'd300000};
    phase_limit = '{4'd8, 4'd2, 4'd1, 4'd5, 4'd15, 4'd3};
    rst_n = 1'b0;
    frame_if.valid = 1'b0;
    frame_if.payload = '0;
    pair_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_MAX_DIFF;
    cfg_data = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    hold_requests = 0;
    holds_done = 0;
    hold_left = 0;
    steady_run = 1'b0;
    held_count[SideLeft] = 0;
    held_count[SideRight] = 0;
    diff_setting = MaxDiffReset;
    limit_setting = FifoLimitReset;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // Reset settings: empty sides, stamp extremes, window edge, first-pair priority,
    // unused mode and dropping the oldest frame on overflow.
    queue_frame(MODE_TICK, 8'd0, 32'd0);
    queue_frame(MODE_LEFT, 8'd0, 32'd0);
    queue_frame(MODE_TICK, 8'hFF, 32'hFFFF_FFFF);
    queue_frame(MODE_RIGHT, 8'hFF, 32'hFFFF_FFFF);
    queue_frame(MODE_TICK, 8'd0, 32'd0);
    queue_frame(MODE_RIGHT, 8'h5A, 32'd49999);
    queue_frame(MODE_TICK, 8'd0, 32'd0);
    queue_frame(ModeUnused, 8'hA5, 32'h5A5A_A5A5);
    queue_frame(MODE_LEFT, 8'd1, 32'd100000);
    queue_frame(MODE_LEFT, 8'd2, 32'd200000);
    queue_frame(MODE_RIGHT, 8'd3, 32'd250000);
    queue_frame(MODE_TICK, 8'd0, 32'd0);
    queue_frame(MODE_RIGHT, 8'd4, 32'd210000);
    queue_frame(MODE_TICK, 8'd0, 32'd0);
    queue_frame(MODE_LEFT, 8'd5, 32'd300000);
    queue_frame(MODE_LEFT, 8'd6, 32'd300010);
    queue_frame(MODE_RIGHT, 8'd7, 32'd300005);
    queue_frame(MODE_RIGHT, 8'd8, 32'd300001);
    queue_frame(MODE_TICK, 8'd0, 32'd0);
    queue_frame(MODE_LEFT, 8'd9, 32'd400000);
    queue_frame(MODE_LEFT, 8'd10, 32'd400001);
    queue_frame(MODE_LEFT, 8'd11, 32'd400002);
    drain();

    // Zero window never matches; a zero limit behaves as one.
    set_reg(REG_MAX_DIFF, 20'd0);
    set_reg(REG_FIFO_LIMIT, 20'd0);
    queue_frame(MODE_LEFT, 8'd12, 32'd500000);
    queue_frame(MODE_RIGHT, 8'd13, 32'd500000);
    queue_frame(MODE_TICK, 8'd0, 32'd0);
    drain();

    // Window at the top of its range and a limit above the depth.
    set_reg(REG_MAX_DIFF, 20'hFFFFF);
    set_reg(REG_FIFO_LIMIT, 20'd15);
    queue_frame(MODE_RIGHT, 8'd14, 32'd1500000);
    queue_frame(MODE_TICK, 8'd0, 32'd0);
    drain();

    // Random phases over a range of settings; the limit drops below the fill level
    // between phases, one phase holds the result side off and one runs without gaps.
    for (p = 0; p < NumPhases; p++) begin
      set_reg(REG_MAX_DIFF, phase_diff[p]);
      set_reg(REG_FIFO_LIMIT, DiffW'(phase_limit[p]));
      steady_run = (p == 3);
      queue_random(PhaseItems);
      if (p == 1) hold_requests++;
      drain();
    end
    steady_run = 1'b0;

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
